// File: src/kvc_pkg.sv
// Shared constants, codes and the controller-to-datapath command type
// for the key/value cache. No dependencies.
package kvc_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned USE_BITS   = 16;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W      = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [1:0] KIND_PUT = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [1:0] POL_NONE = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;
  localparam logic [1:0] POL_LFU  = 2'd3;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_INS    = 3'd1,
    ST_OVER   = 3'd2,
    ST_MISS   = 3'd3,
    ST_REJECT = 3'd4
  } status_e;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic             decide;
    logic             update;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

// File: src/kvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/kvc_ctrl.sv
// Sequencer for the cache: scan pass, decision, rank update pass, finish.
// Depends on kvc_pkg.
module kvc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output kvc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SDRAIN, S_DECIDE, S_UPDATE, S_UDRAIN, S_FINISH
  } state_e;

  localparam logic [kvc_pkg::IDX_W-1:0] LastIdx = kvc_pkg::IDX_W'(kvc_pkg::ENTRIES - 1);

  state_e                      state_q;
  logic [kvc_pkg::IDX_W-1:0]   idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (start_i) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= S_SDRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SDRAIN: state_q <= S_DECIDE;
        S_DECIDE: state_q <= S_UPDATE;
        S_UPDATE: begin
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= S_UDRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_UDRAIN: state_q <= S_FINISH;
        S_FINISH: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.decide = (state_q == S_DECIDE);
    cmd_o.update = (state_q == S_UPDATE);
    cmd_o.finish = (state_q == S_FINISH);
    cmd_o.idx    = idx_q;
  end

  assign busy_o = (state_q != S_IDLE);

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> state_q == S_IDLE) else $error("finish not followed by idle");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN && idx_q == '0) else $error("load did not start scan");
  a_idx_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> idx_q == '0) else $error("index not rewound");

endmodule

// File: src/kvc_dpath.sv
// Datapath: config registers, entry RAMs, valid bits, scan/victim search,
// decision and rank update. Depends on kvc_pkg and kvc_ram.
module kvc_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kvc_pkg::cmd_t cmd_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [6:0]    cfg_data_i,
  input  logic [1:0]    kind_i,
  input  logic [63:0]   key_i,
  input  logic [31:0]   value_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [31:0]   read_value_o,
  output logic          evicted_o,
  output logic [63:0]   evicted_key_o,
  output logic [6:0]    occupancy_o
);

  localparam int unsigned IW = kvc_pkg::IDX_W;
  localparam int unsigned KW = kvc_pkg::KEY_BITS;
  localparam int unsigned VW = kvc_pkg::VALUE_BITS;
  localparam int unsigned UW = kvc_pkg::USE_BITS;
  localparam int unsigned CW = kvc_pkg::CNT_W;
  localparam int unsigned MW = kvc_pkg::CMP_W;

  typedef enum logic [1:0] {OP_NONE, OP_TOUCH, OP_ADD, OP_DROP} rank_op_e;

  // configuration
  logic [1:0] policy_q;
  logic [6:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= kvc_pkg::POL_NONE;
      cap_q    <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kvc_pkg::REG_POLICY:   policy_q <= cfg_data_i[1:0];
        kvc_pkg::REG_CAPACITY: cap_q    <= cfg_data_i;
        default:               policy_q <= policy_q;
      endcase
    end
  end

  // request
  logic [1:0]    kind_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= key_i[KW-1:0];
      val_q  <= VW'(value_i);
    end
  end

  // RAMs
  logic [KW-1:0] key_rd;
  logic [VW-1:0] val_rd;
  logic [IW-1:0] rank_rd;
  logic [UW-1:0] use_rd;
  logic          rank_we;
  logic [IW-1:0] rank_wd;

  logic [IW-1:0] slot_q, wa_q;
  logic          wr_kv_q, wr_use_q;
  logic [UW-1:0] use_wd_q;
  logic          s1_vld_q, s1_upd_q;
  logic [IW-1:0] s1_idx_q;

  kvc_ram #(.WIDTH(KW), .DEPTH(kvc_pkg::ENTRIES)) u_key_ram (
    .clk_i, .we_i(cmd_i.finish && wr_kv_q), .waddr_i(wa_q), .wdata_i(key_q),
    .raddr_i(cmd_i.idx), .rdata_o(key_rd)
  );
  kvc_ram #(.WIDTH(VW), .DEPTH(kvc_pkg::ENTRIES)) u_val_ram (
    .clk_i, .we_i(cmd_i.finish && wr_kv_q), .waddr_i(wa_q), .wdata_i(val_q),
    .raddr_i(slot_q), .rdata_o(val_rd)
  );
  kvc_ram #(.WIDTH(IW), .DEPTH(kvc_pkg::ENTRIES)) u_rank_ram (
    .clk_i, .we_i(rank_we), .waddr_i(s1_idx_q), .wdata_i(rank_wd),
    .raddr_i(cmd_i.idx), .rdata_o(rank_rd)
  );
  kvc_ram #(.WIDTH(UW), .DEPTH(kvc_pkg::ENTRIES)) u_use_ram (
    .clk_i, .we_i(cmd_i.finish && wr_use_q), .waddr_i(wa_q), .wdata_i(use_wd_q),
    .raddr_i(cmd_i.idx), .rdata_o(use_rd)
  );

  // read-data stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_upd_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.scan || cmd_i.update;
      s1_upd_q <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cmd_i.idx;
  end

  logic [kvc_pkg::ENTRIES-1:0] valid_q;
  logic [CW-1:0]               cnt_q;
  logic                        s1_valid;

  assign s1_valid = valid_q[s1_idx_q];

  // scan results
  logic          found_q, vic_found_q, free_found_q;
  logic [IW-1:0] slot_rank_q, vic_q, vic_rank_q, free_q;
  logic [UW-1:0] slot_use_q, vic_use_q;
  logic [KW-1:0] vic_key_q;
  logic          scan_stage, hit, better;

  assign scan_stage = s1_vld_q && !s1_upd_q;
  assign hit        = scan_stage && s1_valid && !found_q && (key_rd == key_q);

  always_comb begin
    if (!vic_found_q) begin
      better = 1'b1;
    end else if (policy_q == kvc_pkg::POL_LFU) begin
      better = (use_rd < vic_use_q) || ((use_rd == vic_use_q) && (rank_rd < vic_rank_q));
    end else begin
      better = rank_rd > vic_rank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q      <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (scan_stage) begin
      if (hit) found_q <= 1'b1;
      if (s1_valid && better) vic_found_q <= 1'b1;
      if (!s1_valid) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      slot_q      <= s1_idx_q;
      slot_rank_q <= rank_rd;
      slot_use_q  <= use_rd;
    end
    if (scan_stage && s1_valid && better) begin
      vic_q      <= s1_idx_q;
      vic_rank_q <= rank_rd;
      vic_use_q  <= use_rd;
      vic_key_q  <= key_rd;
    end
    if (scan_stage && !s1_valid && !free_found_q) begin
      free_q <= s1_idx_q;
    end
  end

  // decision
  logic [MW-1:0] cap_ext, cap_eff;
  logic          full;

  always_comb begin
    cap_ext = MW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = MW'(1);
    end else if (cap_ext > MW'(kvc_pkg::ENTRIES)) begin
      cap_eff = MW'(kvc_pkg::ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full = MW'(cnt_q) >= cap_eff;

  rank_op_e         op_d, op_q;
  kvc_pkg::status_e st_d, st_q;
  logic [IW-1:0]    tgt_d, tgt_q, r_d, r_q, excl_d, excl_q, wa_d;
  logic             has_tgt_d, has_tgt_q, evict_d, evict_q, excl_en_d, excl_en_q;
  logic             set_en_d, set_en_q, wr_kv_d, wr_use_d, rd_en_d, rd_en_q;
  logic [UW-1:0]    use_wd_d;

  always_comb begin
    op_d      = OP_NONE;
    st_d      = kvc_pkg::ST_MISS;
    tgt_d     = slot_q;
    r_d       = slot_rank_q;
    excl_d    = slot_q;
    wa_d      = slot_q;
    has_tgt_d = 1'b0;
    evict_d   = 1'b0;
    excl_en_d = 1'b0;
    set_en_d  = 1'b0;
    wr_kv_d   = 1'b0;
    wr_use_d  = 1'b0;
    rd_en_d   = 1'b0;
    use_wd_d  = '0;
    case (kind_q)
      kvc_pkg::KIND_PUT: begin
        if (found_q) begin
          st_d      = kvc_pkg::ST_OVER;
          op_d      = OP_TOUCH;
          has_tgt_d = 1'b1;
          wr_kv_d   = 1'b1;
          wr_use_d  = 1'b1;
        end else if (full && (policy_q == kvc_pkg::POL_NONE)) begin
          st_d = kvc_pkg::ST_REJECT;
        end else if (!free_found_q && !(full && vic_found_q)) begin
          st_d = kvc_pkg::ST_REJECT;
        end else begin
          evict_d   = full && vic_found_q;
          st_d      = kvc_pkg::ST_INS;
          op_d      = OP_ADD;
          r_d       = vic_rank_q;
          excl_d    = vic_q;
          excl_en_d = evict_d;
          tgt_d     = (evict_d && (!free_found_q || (vic_q < free_q))) ? vic_q : free_q;
          wa_d      = tgt_d;
          has_tgt_d = 1'b1;
          set_en_d  = 1'b1;
          wr_kv_d   = 1'b1;
          wr_use_d  = 1'b1;
        end
      end
      kvc_pkg::KIND_GET: begin
        if (found_q) begin
          st_d    = kvc_pkg::ST_HIT;
          rd_en_d = 1'b1;
          if ((policy_q == kvc_pkg::POL_LRU) || (policy_q == kvc_pkg::POL_LFU)) begin
            op_d      = OP_TOUCH;
            has_tgt_d = 1'b1;
          end
          if ((policy_q == kvc_pkg::POL_LFU) && (slot_use_q != '1)) begin
            wr_use_d = 1'b1;
            use_wd_d = slot_use_q + 1'b1;
          end
        end
      end
      kvc_pkg::KIND_DEL: begin
        if (found_q) begin
          st_d      = kvc_pkg::ST_HIT;
          op_d      = OP_DROP;
          excl_en_d = 1'b1;
        end
      end
      default: st_d = kvc_pkg::ST_MISS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_NONE;
      has_tgt_q <= 1'b0;
      excl_en_q <= 1'b0;
      set_en_q  <= 1'b0;
      wr_kv_q   <= 1'b0;
      wr_use_q  <= 1'b0;
      evict_q   <= 1'b0;
      rd_en_q   <= 1'b0;
    end else if (cmd_i.decide) begin
      op_q      <= op_d;
      has_tgt_q <= has_tgt_d;
      excl_en_q <= excl_en_d;
      set_en_q  <= set_en_d;
      wr_kv_q   <= wr_kv_d;
      wr_use_q  <= wr_use_d;
      evict_q   <= evict_d;
      rd_en_q   <= rd_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      st_q     <= st_d;
      tgt_q    <= tgt_d;
      r_q      <= r_d;
      excl_q   <= excl_d;
      wa_q     <= wa_d;
      use_wd_q <= use_wd_d;
    end
  end

  // rank update pass
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_rd;
    if (s1_vld_q && s1_upd_q) begin
      if (has_tgt_q && (s1_idx_q == tgt_q)) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (s1_valid && !(excl_en_q && (s1_idx_q == excl_q))) begin
        case (op_q)
          OP_TOUCH: begin
            if (rank_rd < r_q) begin
              rank_we = 1'b1;
              rank_wd = rank_rd + 1'b1;
            end
          end
          OP_ADD: begin
            rank_we = 1'b1;
            rank_wd = (evict_q && (rank_rd > r_q)) ? rank_rd : rank_rd + 1'b1;
          end
          OP_DROP: begin
            if (rank_rd > r_q) begin
              rank_we = 1'b1;
              rank_wd = rank_rd - 1'b1;
            end
          end
          default: rank_we = 1'b0;
        endcase
      end
    end
  end

  // finish: occupancy, valid bits, result beat
  logic [CW-1:0]               cnt_d;
  logic [kvc_pkg::ENTRIES-1:0] valid_d;

  assign cnt_d = cnt_q - CW'(excl_en_q) + CW'(set_en_q);

  always_comb begin
    valid_d = valid_q;
    if (excl_en_q) valid_d[excl_q] = 1'b0;
    if (set_en_q) valid_d[tgt_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.finish) begin
        valid_q <= valid_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o      <= st_q;
      read_value_o  <= rd_en_q ? 32'(val_rd) : '0;
      evicted_o     <= evict_q;
      evicted_key_o <= evict_q ? 64'(vic_key_q) : '0;
      occupancy_o   <= 7'(cnt_d);
    end
  end

  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q)) else $error("occupancy out of step with valid bits");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= kvc_pkg::ENTRIES) else $error("occupancy above entries");
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");
  a_evict_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> status_o == kvc_pkg::ST_INS) else $error("eviction without insert");

endmodule

// File: src/key_value_cache_with_replacement_unit.sv
// Key/value cache with capacity limit and replacement policy.
// Top level; depends on kvc_pkg, kvc_ctrl, kvc_dpath (and kvc_ram).
//
// Usage:
//   Command channel: drive kind_i/key_i/value_i with start_i; the beat is
//   taken on a rising edge with start_i high and busy_o low. kind is
//   put, get or delete.
//   Result channel: done_o is high for exactly one cycle with status_o,
//   read_value_o, evicted_o, evicted_key_o and occupancy_o. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 policy,
//   1 capacity) at once; write only while busy_o is low.
// Sequence: each command makes one scan pass over the key/rank/use RAMs for
//   match, victim and free slot, a drain step, a decision step, a
//   read-modify-write pass over the rank RAM, a drain step and a finish
//   step. done_o is high in the first cycle with busy_o low; a new
//   command may be taken in that same cycle.
// Reset: table empty, policy none, capacity 64. Entry RAMs are not cleared;
//   per-entry valid bits gate every read.
module key_value_cache_with_replacement_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  output logic [63:0] evicted_key_o,
  output logic [6:0]  occupancy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  kvc_pkg::cmd_t cmd;
  logic          busy;

  kvc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o(busy), .cmd_o(cmd)
  );

  kvc_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i, .key_i, .value_i,
    .done_o, .status_o, .read_value_o, .evicted_o, .evicted_key_o, .occupancy_o
  );

  assign busy_o = busy;

endmodule
